[sv/bgeu_pkg.sv]
// ----------------------------------------------------------------------------
// bgeu_pkg
// shared constants, codes, request/status types and helpers for the gravity
// euler step block
// ----------------------------------------------------------------------------
package bgeu_pkg;

  localparam int FRAC_BITS = 16;

  // G = 0.6674 as unsigned Q0.32, rounded to nearest at FRAC_BITS fraction bits
  localparam logic [63:0] G_Q32   = 64'd2866461173;
  localparam logic [63:0] GF_FULL = (G_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam int          GF_W    = FRAC_BITS;
  localparam logic [GF_W-1:0] GF  = GF_FULL[GF_W-1:0];

  // G*m width, dividend width of g = G*m*2^(2F)/s, and divider step counter width
  localparam int GM_W  = 32 + GF_W;
  localparam int DIV_W = GM_W + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam logic [31:0] TIME_STEP_RST = 32'd429497;

  localparam logic [2:0] REG_START_POS_X = 3'd0;
  localparam logic [2:0] REG_START_POS_Y = 3'd1;
  localparam logic [2:0] REG_START_VEL_X = 3'd2;
  localparam logic [2:0] REG_START_VEL_Y = 3'd3;
  localparam logic [2:0] REG_TIME_STEP   = 3'd4;

  localparam logic [1:0] CMD_GRAVITY = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_LOAD    = 2'd2;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] root;
  } sqrt_sts_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
    logic [63:0]      rem_init;
    logic [DIV_W-1:0] num;
    logic [63:0]      den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
    logic        ovf;
  } div_sts_t;

  typedef struct packed {
    logic        clip;
    logic [31:0] val;
  } sat_t;

  localparam logic signed [33:0] MAX34 = 34'sd2147483647;
  localparam logic signed [33:0] MIN34 = -34'sd2147483648;

  function automatic sat_t sat32(input logic signed [33:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[31:0];
    if (v > MAX34) begin
      r.clip = 1'b1;
      r.val  = 32'h7fff_ffff;
    end else if (v < MIN34) begin
      r.clip = 1'b1;
      r.val  = 32'h8000_0000;
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

[sv/bgeu_mul.sv]
// ----------------------------------------------------------------------------
// bgeu_mul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module bgeu_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

[sv/bgeu_sqrt.sv]
// ----------------------------------------------------------------------------
// bgeu_sqrt
// bit-pair integer square root of a 64-bit value, one step per cycle
// ----------------------------------------------------------------------------
module bgeu_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bgeu_pkg::sqrt_req_t req_i,
  output bgeu_pkg::sqrt_sts_t sts_o
);
  import bgeu_pkg::*;

  logic [63:0] n_q, res_q, bit_q;
  logic        done_q;
  logic [63:0] sum;
  logic        ge;

  assign sum = res_q + bit_q;
  assign ge  = (n_q >= sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (bit_q == 64'd1);
      if (req_i.start) begin
        bit_q <= 64'd1 << 62;
      end else begin
        bit_q <= bit_q >> 2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q   <= req_i.radicand;
      res_q <= '0;
    end else if (bit_q != 64'd0) begin
      if (ge) begin
        n_q   <= n_q - sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign sts_o.busy = (bit_q != 64'd0);
  assign sts_o.done = done_q;
  assign sts_o.root = res_q[31:0];

endmodule

[sv/bgeu_div.sv]
// ----------------------------------------------------------------------------
// bgeu_div
// restoring divider, one quotient bit per cycle, flags a quotient past 2^31-1
// ----------------------------------------------------------------------------
module bgeu_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bgeu_pkg::div_req_t req_i,
  output bgeu_pkg::div_sts_t sts_o
);
  import bgeu_pkg::*;

  logic [63:0]      rem_q;
  logic [DIV_W-1:0] num_q;
  logic [63:0]      den_q;
  logic [31:0]      q_q;
  logic             ovf_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [64:0]      rem_sh;
  logic [64:0]      rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, num_q[DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        cnt_q <= req_i.iters;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      num_q <= req_i.num;
      den_q <= req_i.den;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (cnt_q != '0) begin
      // the remainder stays below the divisor, so 64 bits hold it
      rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
      num_q <= num_q << 1;
      q_q   <= {q_q[30:0], ge};
      // a bit leaving position 31 means the quotient is past the 31-bit range
      ovf_q <= ovf_q | q_q[31];
    end
  end

  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.done = done_q;
  assign sts_o.quo  = q_q;
  assign sts_o.ovf  = ovf_q | q_q[31];

endmodule

[sv/body_gravity_euler_step_top.sv]
// ----------------------------------------------------------------------------
// body_gravity_euler_step_top
// one body's 2-D gravity accumulation and semi-implicit euler integration
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  in       | in_valid_i / in_stall_o  | command, other_x, other_y, other_mass
//  out      | out_valid_o / out_stall_i| pos_x/y, vel_x/y, coincident, saturated
//  cfg      | cfg_we_i                 | cfg_index_i, cfg_data_i
//
//  a gravity beat runs after acceptance through six set-up steps, the square
//  root (32 steps), the 80-step division for g and per axis a 31-step
//  division for the direction on one restoring divider; a coincident body
//  skips the root and the divisions, a tick runs on the shared multiplier,
//  and a load or an unused command goes straight to completion.
//  in_stall_o is high from acceptance until the result enters the output
//  register, so the next beat is taken in the cycle after that at the earliest;
//  that register holds the result while out_stall_i is high.
//  reset clears state to zero and time_step to its default.
module body_gravity_euler_step_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] other_x_i,
  input  logic [31:0] other_y_i,
  input  logic [31:0] other_mass_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [31:0] vel_x_o,
  output logic [31:0] vel_y_o,
  output logic        coincident_o,
  output logic        saturated_o
);
  import bgeu_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DIFF   = 5'd1;
  localparam logic [4:0] ST_SQ0    = 5'd2;
  localparam logic [4:0] ST_SQ1    = 5'd3;
  localparam logic [4:0] ST_SQSUM  = 5'd4;
  localparam logic [4:0] ST_CHK    = 5'd5;
  localparam logic [4:0] ST_GM     = 5'd6;
  localparam logic [4:0] ST_SQRT   = 5'd7;
  localparam logic [4:0] ST_DIVGST = 5'd8;
  localparam logic [4:0] ST_DIVG   = 5'd9;
  localparam logic [4:0] ST_UST    = 5'd10;
  localparam logic [4:0] ST_UDIV   = 5'd11;
  localparam logic [4:0] ST_GU     = 5'd12;
  localparam logic [4:0] ST_ACC    = 5'd13;
  localparam logic [4:0] ST_T0     = 5'd14;
  localparam logic [4:0] ST_T1     = 5'd15;
  localparam logic [4:0] ST_T2     = 5'd16;
  localparam logic [4:0] ST_T3     = 5'd17;
  localparam logic [4:0] ST_DONE   = 5'd18;

  logic [4:0]  state_q, state_d;
  logic        ax_q;
  logic [31:0] start_pos_q [2];
  logic [31:0] start_vel_q [2];
  logic [31:0] time_step_q;
  logic [31:0] pos_q [2];
  logic [31:0] vel_q [2];
  logic [31:0] acc_q [2];
  logic [31:0] oth_q [2];
  logic [31:0] mass_q;
  logic [31:0] d_q [2];
  logic [63:0] s_q;
  logic [GM_W-1:0] gm_q;
  logic [31:0] r_q, g_q, u_q;
  logic        coin_q, clip_q;
  logic        out_valid_q;
  logic [31:0] out_pos_q [2];
  logic [31:0] out_vel_q [2];
  logic        out_coin_q, out_clip_q;

  logic        in_acc, out_free;
  logic [31:0] ad [2];
  sat_t        dsat [2];
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] upd_base, upd_mag;
  logic        upd_neg;
  logic [33:0] upd_add;
  sat_t        upd;
  sqrt_req_t   sqrt_req;
  sqrt_sts_t   sqrt_sts;
  div_req_t    div_req;
  div_sts_t    div_sts;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dsat[i] = sat32($signed({{2{pos_q[i][31]}}, pos_q[i]})
                      - $signed({{2{oth_q[i][31]}}, oth_q[i]}));
      ad[i]   = abs32(d_q[i]);
    end
  end

  bgeu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  bgeu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .sts_o  (sqrt_sts)
  );

  bgeu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts)
  );

  // multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ0: begin
        mul_a = ad[0];
        mul_b = ad[0];
      end
      ST_SQ1: begin
        mul_a = ad[1];
        mul_b = ad[1];
      end
      ST_CHK: begin
        mul_a = 32'(GF);
        mul_b = mass_q;
      end
      ST_GU: begin
        mul_a = g_q;
        mul_b = u_q;
      end
      ST_T0: begin
        mul_a = abs32(acc_q[ax_q]);
        mul_b = time_step_q;
      end
      ST_T2: begin
        mul_a = abs32(vel_q[ax_q]);
        mul_b = time_step_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // one saturating accumulate shared by acceleration, velocity and position
  always_comb begin
    upd_base = acc_q[ax_q];
    upd_mag  = mul_p[61:30];
    upd_neg  = !d_q[ax_q][31];
    case (state_q)
      ST_T1: begin
        upd_base = vel_q[ax_q];
        upd_mag  = mul_p[63:32];
        upd_neg  = acc_q[ax_q][31];
      end
      ST_T3: begin
        upd_base = pos_q[ax_q];
        upd_mag  = mul_p[63:32];
        upd_neg  = vel_q[ax_q][31];
      end
      default: begin
        upd_base = acc_q[ax_q];
        upd_mag  = mul_p[61:30];
        upd_neg  = !d_q[ax_q][31];
      end
    endcase
    upd_add = upd_neg ? (34'd0 - {2'b00, upd_mag}) : {2'b00, upd_mag};
    upd     = sat32($signed({{2{upd_base[31]}}, upd_base}) + $signed(upd_add));
  end

  always_comb begin
    sqrt_req.start    = (state_q == ST_GM);
    sqrt_req.radicand = s_q;
    div_req.start     = (state_q == ST_DIVGST) || (state_q == ST_UST);
    if (state_q == ST_UST) begin
      // |d|*2^30 / r: top part |d|/2 is already below r, so 31 steps remain
      div_req.iters    = CNT_W'(31);
      div_req.rem_init = 64'(ad[ax_q] >> 1);
      div_req.num      = {ad[ax_q][0], {(DIV_W-1){1'b0}}};
      div_req.den      = 64'(r_q);
    end else begin
      div_req.iters    = CNT_W'(DIV_W);
      div_req.rem_init = '0;
      div_req.num      = {gm_q, {(2*FRAC_BITS){1'b0}}};
      div_req.den      = s_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (command_i)
            CMD_GRAVITY: state_d = ST_DIFF;
            CMD_TICK:    state_d = ST_T0;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_DIFF:   state_d = ST_SQ0;
      ST_SQ0:    state_d = ST_SQ1;
      ST_SQ1:    state_d = ST_SQSUM;
      ST_SQSUM:  state_d = ST_CHK;
      ST_CHK:    state_d = (s_q == 64'd0) ? ST_DONE : ST_GM;
      ST_GM:     state_d = ST_SQRT;
      ST_SQRT:   state_d = sqrt_sts.done ? ST_DIVGST : ST_SQRT;
      ST_DIVGST: state_d = ST_DIVG;
      ST_DIVG:   state_d = div_sts.done ? ST_UST : ST_DIVG;
      ST_UST:    state_d = ST_UDIV;
      ST_UDIV:   state_d = div_sts.done ? ST_GU : ST_UDIV;
      ST_GU:     state_d = ST_ACC;
      ST_ACC:    state_d = ax_q ? ST_DONE : ST_UST;
      ST_T0:     state_d = ST_T1;
      ST_T1:     state_d = ST_T2;
      ST_T2:     state_d = ST_T3;
      ST_T3:     state_d = ax_q ? ST_DONE : ST_T0;
      ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= 1'b0;
      out_valid_q <= 1'b0;
      start_pos_q <= '{default: '0};
      start_vel_q <= '{default: '0};
      time_step_q <= TIME_STEP_RST;
      pos_q       <= '{default: '0};
      vel_q       <= '{default: '0};
      acc_q       <= '{default: '0};
      coin_q      <= 1'b0;
      clip_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_START_POS_X: start_pos_q[0] <= cfg_data_i;
          REG_START_POS_Y: start_pos_q[1] <= cfg_data_i;
          REG_START_VEL_X: start_vel_q[0] <= cfg_data_i;
          REG_START_VEL_Y: start_vel_q[1] <= cfg_data_i;
          REG_TIME_STEP:   time_step_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          ax_q <= 1'b0;
          if (in_acc) begin
            coin_q <= 1'b0;
            clip_q <= 1'b0;
            if (command_i == CMD_LOAD) begin
              pos_q <= start_pos_q;
              vel_q <= start_vel_q;
              acc_q <= '{default: '0};
            end
          end
        end
        ST_DIFF: clip_q <= dsat[0].clip | dsat[1].clip;
        ST_CHK: begin
          if (s_q == 64'd0) begin
            coin_q <= 1'b1;
          end
        end
        ST_DIVG: begin
          if (div_sts.done) begin
            clip_q <= clip_q | div_sts.ovf;
          end
        end
        ST_ACC: begin
          acc_q[ax_q] <= upd.val;
          clip_q      <= clip_q | upd.clip;
          ax_q        <= 1'b1;
        end
        ST_T1: begin
          vel_q[ax_q] <= upd.val;
          clip_q      <= clip_q | upd.clip;
        end
        ST_T3: begin
          pos_q[ax_q] <= upd.val;
          acc_q[ax_q] <= '0;
          clip_q      <= clip_q | upd.clip;
          ax_q        <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      oth_q[0] <= other_x_i;
      oth_q[1] <= other_y_i;
      mass_q   <= other_mass_i;
    end
    if (state_q == ST_DIFF) begin
      d_q[0] <= dsat[0].val;
      d_q[1] <= dsat[1].val;
    end
    if (state_q == ST_SQ1) begin
      s_q <= mul_p;
    end
    if (state_q == ST_SQSUM) begin
      s_q <= s_q + mul_p;
    end
    if (state_q == ST_GM) begin
      gm_q <= mul_p[GM_W-1:0];
    end
    if (state_q == ST_SQRT && sqrt_sts.done) begin
      r_q <= sqrt_sts.root;
    end
    if (state_q == ST_DIVG && div_sts.done) begin
      g_q <= div_sts.ovf ? 32'h7fff_ffff : div_sts.quo;
    end
    if (state_q == ST_UDIV && div_sts.done) begin
      u_q <= div_sts.quo;
    end
    if (state_q == ST_DONE && out_free) begin
      out_pos_q  <= pos_q;
      out_vel_q  <= vel_q;
      out_coin_q <= coin_q;
      out_clip_q <= clip_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pos_x_o      = out_pos_q[0];
  assign pos_y_o      = out_pos_q[1];
  assign vel_x_o      = out_vel_q[0];
  assign vel_y_o      = out_vel_q[1];
  assign coincident_o = out_coin_q;
  assign saturated_o  = out_clip_q;

  a_units_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sqrt_sts.busy && div_sts.busy))
    else $error("square root and divider busy together");

  a_dir_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UDIV && div_sts.done) |-> !div_sts.ovf)
    else $error("direction quotient out of range");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result beat loaded outside completion step");

endmodule

[tb/bgeu_checker.sv]
// ----------------------------------------------------------------------------
// bgeu_checker
// watches the config port and both channels of the gravity euler step block,
// keeps its own copy of the body state, predicts every result beat and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module bgeu_checker
  import bgeu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] other_x_i,
  input  logic [31:0] other_y_i,
  input  logic [31:0] other_mass_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic        coincident_i,
  input  logic        saturated_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic        coincident;
    logic        saturated;
  } body_result_t;

  localparam logic signed [63:0] INT32_HI = 64'sd2147483647;
  localparam logic signed [63:0] INT32_LO = -64'sd2147483648;

  body_result_t      body_results_q[$];
  logic signed [31:0] body_pos[2];
  logic signed [31:0] body_vel[2];
  logic signed [31:0] body_acc[2];
  logic [31:0]        start_val[4];
  logic [31:0]        dt;
  int                 fails;
  int                 checked;

  assign fail_count_o = fails;
  assign pending_o    = body_results_q.size();
  assign checked_o    = checked;

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v,
                                                 inout logic clip);
    if (v > INT32_HI) begin
      clip = 1'b1;
      return INT32_HI[31:0];
    end
    if (v < INT32_LO) begin
      clip = 1'b1;
      return INT32_LO[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // x*dt truncated toward zero
  function automatic logic signed [63:0] scale_by_dt(input logic signed [31:0] x);
    logic [63:0] mag;
    mag = x[31] ? 64'(-64'sd1 * 64'(x)) : 64'(x);
    mag = (mag * 64'(dt)) >> 32;
    return x[31] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic add_gravity(input logic [31:0] ox, input logic [31:0] oy,
                                       input logic [31:0] mass, inout logic clip);
    logic signed [63:0] d[2];
    logic [63:0]        ad[2];
    logic [63:0]        s, r, g, u, mag, gm;
    logic [127:0]       g_wide;
    logic signed [63:0] other[2];
    other[0] = 64'($signed(ox));
    other[1] = 64'($signed(oy));
    for (int i = 0; i < 2; i++) begin
      d[i]  = 64'(clip32(64'(body_pos[i]) - other[i], clip));
      ad[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
    end
    s = ad[0] * ad[0] + ad[1] * ad[1];
    if (s == 0) return 1'b1;
    r      = floor_sqrt(s);
    gm     = GF_FULL * 64'(mass);
    g_wide = (128'(gm) << (2 * FRAC_BITS)) / 128'(s);
    if (g_wide > 128'(INT32_HI)) begin
      clip = 1'b1;
      g    = 64'(INT32_HI);
    end else begin
      g = g_wide[63:0];
    end
    for (int i = 0; i < 2; i++) begin
      u   = (ad[i] << 30) / r;
      mag = (g * u) >> 30;
      body_acc[i] = clip32(64'(body_acc[i]) + (d[i] < 0 ? $signed(mag) : -$signed(mag)),
                           clip);
    end
    return 1'b0;
  endfunction

  function automatic body_result_t predict_body(input logic [1:0] cmd,
                                                input logic [31:0] ox,
                                                input logic [31:0] oy,
                                                input logic [31:0] mass);
    body_result_t res;
    logic clip;
    logic coin;
    clip = 1'b0;
    coin = 1'b0;
    case (cmd)
      CMD_GRAVITY: begin
        coin = add_gravity(ox, oy, mass, clip);
      end
      CMD_TICK: begin
        for (int i = 0; i < 2; i++) begin
          body_vel[i] = clip32(64'(body_vel[i]) + scale_by_dt(body_acc[i]), clip);
          body_pos[i] = clip32(64'(body_pos[i]) + scale_by_dt(body_vel[i]), clip);
          body_acc[i] = '0;
        end
      end
      CMD_LOAD: begin
        body_pos[0] = start_val[REG_START_POS_X[1:0]];
        body_pos[1] = start_val[REG_START_POS_Y[1:0]];
        body_vel[0] = start_val[REG_START_VEL_X[1:0]];
        body_vel[1] = start_val[REG_START_VEL_Y[1:0]];
        body_acc[0] = '0;
        body_acc[1] = '0;
      end
      default: ;
    endcase
    res.pos_x      = body_pos[0];
    res.pos_y      = body_pos[1];
    res.vel_x      = body_vel[0];
    res.vel_y      = body_vel[1];
    res.coincident = coin;
    res.saturated  = clip;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    body_result_t want;
    if (!rst_ni) begin
      body_results_q.delete();
      for (int i = 0; i < 2; i++) begin
        body_pos[i] = '0;
        body_vel[i] = '0;
        body_acc[i] = '0;
      end
      for (int i = 0; i < 4; i++) start_val[i] = '0;
      dt      = TIME_STEP_RST;
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_TIME_STEP) dt = cfg_data_i;
        else if (cfg_index_i < REG_TIME_STEP) start_val[cfg_index_i[1:0]] = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (body_results_q.size() == 0) begin
          report_mismatch("unexpected result beat", 32'(out_valid_i), 32'd0);
        end else begin
          want = body_results_q.pop_front();
          checked++;
          if (pos_x_i !== want.pos_x) report_mismatch("pos_x", pos_x_i, want.pos_x);
          if (pos_y_i !== want.pos_y) report_mismatch("pos_y", pos_y_i, want.pos_y);
          if (vel_x_i !== want.vel_x) report_mismatch("vel_x", vel_x_i, want.vel_x);
          if (vel_y_i !== want.vel_y) report_mismatch("vel_y", vel_y_i, want.vel_y);
          if (coincident_i !== want.coincident)
            report_mismatch("coincident", 32'(coincident_i), 32'(want.coincident));
          if (saturated_i !== want.saturated)
            report_mismatch("saturated", 32'(saturated_i), 32'(want.saturated));
        end
      end
      if (in_valid_i && !in_stall_i)
        body_results_q.insert(body_results_q.size(),
                              predict_body(command_i, other_x_i, other_y_i,
                                           other_mass_i));
    end
  end

endmodule

[tb/body_gravity_euler_step_top_tb.sv]
// ----------------------------------------------------------------------------
// body_gravity_euler_step_top_tb
// drives gravity, tick, load and unused beats into the gravity euler step
// block under several idling patterns and register settings; the checker
// beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module body_gravity_euler_step_top_tb;
  import bgeu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 3000000;
  localparam int         HOLD_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_GRAVITY;
  logic [31:0] other_x = '0;
  logic [31:0] other_y = '0;
  logic [31:0] other_mass = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pos_x, pos_y, vel_x, vel_y;
  logic        coincident, saturated;

  int fail_count, pending, checked;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cmd_count[4];
  logic [31:0] start_x, start_y;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  body_gravity_euler_step_top i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .other_x_i    (other_x),
    .other_y_i    (other_y),
    .other_mass_i (other_mass),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .vel_x_o      (vel_x),
    .vel_y_o      (vel_y),
    .coincident_o (coincident),
    .saturated_o  (saturated)
  );

  bgeu_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .command_i    (command),
    .other_x_i    (other_x),
    .other_y_i    (other_y),
    .other_mass_i (other_mass),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .vel_x_i      (vel_x),
    .vel_y_i      (vel_y),
    .coincident_i (coincident),
    .saturated_i  (saturated),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  task automatic write_body_regs(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] vx, input logic [31:0] vy,
                                 input logic [31:0] step);
    logic [31:0] vals[5];
    vals = '{px, py, vx, vy, step};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    start_x = px;
    start_y = py;
  endtask

  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] ox,
                           input logic [31:0] oy, input logic [31:0] mass);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    other_x    <= ox;
    other_y    <= oy;
    other_mass <= mass;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    cmd_count[cmd]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2, 3, 4: return 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
      default: return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
    endcase
  endfunction

  task automatic send_random_beat();
    int          sel;
    logic [31:0] mass;
    sel  = $urandom_range(0, 99);
    mass = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 5000);
    if (sel < 50)      send_beat(CMD_GRAVITY, pick_coord(), pick_coord(), mass);
    else if (sel < 75) send_beat(CMD_TICK, $urandom(), $urandom(), $urandom());
    else if (sel < 85) begin
      // a load followed by a body sitting exactly on the start position
      send_beat(CMD_LOAD, $urandom(), $urandom(), $urandom());
      send_beat(CMD_GRAVITY, start_x, start_y, mass);
    end else if (sel < 92) send_beat(CMD_UNUSED, $urandom(), $urandom(), $urandom());
    else send_beat(CMD_GRAVITY, $urandom(), $urandom(), $urandom());
  endtask

  initial begin
    int idle_tx[4];
    int idle_rx[4];
    idle_tx = '{0, 59, 0, 34};
    idle_rx = '{0, 0, 59, 34};
    for (int i = 0; i < 4; i++) cmd_count[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: coincident body, clipped difference, zero and huge mass
    write_body_regs(32'h000a_0000, 32'hffec_0000, 32'h0001_0000, 32'h7fff_ffff,
                    TIME_STEP_RST);
    send_beat(CMD_LOAD, '0, '0, '0);
    send_beat(CMD_GRAVITY, 32'h000a_0000, 32'hffec_0000, 32'd1000);
    send_beat(CMD_GRAVITY, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_beat(CMD_GRAVITY, 32'h0000_0000, 32'h0000_0000, 32'd0);
    send_beat(CMD_GRAVITY, 32'h000a_0001, 32'hffec_0000, 32'hffff_ffff);
    send_beat(CMD_TICK, '0, '0, '0);
    send_beat(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CMD_GRAVITY, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_beat(CMD_TICK, '0, '0, '0);
    drain_results();
    write_body_regs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                    32'hffff_ffff);
    send_beat(CMD_LOAD, '0, '0, '0);
    send_beat(CMD_TICK, '0, '0, '0);
    send_beat(CMD_GRAVITY, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_beat(CMD_TICK, '0, '0, '0);
    send_beat(CMD_LOAD, '0, '0, '0);
    send_beat(CMD_GRAVITY, 32'h7fff_0000, 32'h8000_ffff, 32'd77);
    send_beat(CMD_TICK, '0, '0, '0);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = idle_tx[ph];
      rx_stall_pct = idle_rx[ph];
      case (ph)
        0: write_body_regs('0, '0, '0, '0, 32'd0);
        1: write_body_regs($urandom(), $urandom(), $urandom(), $urandom(), 32'hffff_ffff);
        default: write_body_regs(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                                 $urandom());
      endcase
      send_beat(CMD_LOAD, '0, '0, '0);
      if (ph == 0) begin
        // long receiver hold-off while beats keep coming
        hold_seq++;
        repeat (6) send_random_beat();
        drain_results();
      end
      repeat (230) send_random_beat();
      drain_results();
    end

    repeat (300) @(posedge clk);
    $display("beats sent: %0d gravity, %0d tick, %0d load, %0d unused command",
             cmd_count[CMD_GRAVITY], cmd_count[CMD_TICK], cmd_count[CMD_LOAD],
             cmd_count[CMD_UNUSED]);
    $display("%0d results checked over four idling patterns and register sets", checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
